// ----- hw/rtl/qwsc_pkg.sv -----
// Shared constants, types and table-generation functions for the sine/cosine lookup.
package qwsc_pkg;

  // Default quarter-wave table resolution
  localparam int unsigned TableBitsDef = 8;

  // Sample and phase geometry
  localparam int unsigned SampleWidth  = 16;
  localparam int unsigned MagW         = SampleWidth - 1;
  localparam int unsigned PhaseW       = 15;
  localparam int unsigned QuarterBits  = 13;
  localparam int unsigned SeriesTerms  = 12;

  localparam logic [PhaseW-1:0] HalfTurn    = 15'h4000;
  localparam logic [PhaseW-1:0] QuarterTurn = 15'h2000;
  localparam logic [MagW-1:0]   MaxQ        = {MagW{1'b1}};

  // pi/2 in unsigned Q31
  localparam logic [63:0] PiHalfQ31 = 64'd3373259426;

  // Per-channel interpolation controls
  typedef struct packed {
    logic            neg;
    logic [MagW-1:0] frac;
  } interp_ctl_t;

  // Divide a series term by (2k)(2k+1)
  function automatic logic [63:0] div_term(input logic [63:0] term, input int unsigned k);
    logic [63:0] res;
    begin
      case (k)
        1:       res = term / 64'd6;
        2:       res = term / 64'd20;
        3:       res = term / 64'd42;
        4:       res = term / 64'd72;
        5:       res = term / 64'd110;
        6:       res = term / 64'd156;
        7:       res = term / 64'd210;
        8:       res = term / 64'd272;
        9:       res = term / 64'd342;
        10:      res = term / 64'd420;
        11:      res = term / 64'd506;
        default: res = term / 64'd600;
      endcase
      return res;
    end
  endfunction

  // Table entry i: sin(pi/2 * i / 2^table_bits), rounded and saturated magnitude
  function automatic logic [MagW-1:0] sine_entry(input int unsigned i,
                                                input int unsigned table_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    begin
      x    = (PiHalfQ31 * 64'(i)) >> table_bits;
      x2   = (x * x) >> 31;
      term = x;
      sum  = x;
      for (int unsigned k = 1; k <= SeriesTerms; k++) begin
        term = div_term((term * x2) >> 31, k);
        if (k[0]) begin
          sum = (sum >= term) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      v = (sum + (64'd1 << (32 - SampleWidth - 1))) >> (32 - SampleWidth);
      if (v > 64'(MaxQ)) begin
        v = 64'(MaxQ);
      end
      return v[MagW-1:0];
    end
  endfunction

endpackage

// ----- hw/rtl/quarter_wave_sincos_lookup_top.sv -----
// Quarter-wave sine/cosine lookup top level: table fill, fold, RAM read, interpolation.
// Takes one Q15 angle per cycle (1.0 = one turn) and returns interpolated Q15 sine
// and cosine through registered steps for the table RAM read, the difference multiply
// and the add and sign into the output register.
// Both phases read one dual-read-port table RAM whose entries hold neighboring sample
// pairs, so throughput is one item per cycle as long as the output side takes them;
// a stall on the output freezes the whole pipeline. After reset the table RAM is
// filled from constant contents, all 2^TableBits entries (256 at the default), during
// which s_axis_tready stays low.
module quarter_wave_sincos_lookup_top #(
  parameter int unsigned TableBits = qwsc_pkg::TableBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] angle
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // [15:0] sin_value, [31:16] cos_value
);
  import qwsc_pkg::*;

  localparam int unsigned TableSize = 1 << TableBits;
  localparam int unsigned PairW     = 2 * MagW;

  // Constant pair table: entry i holds {sample i+1, sample i}
  logic [PairW-1:0] fill_tbl [TableSize];
  for (genvar g = 0; g < TableSize; g++) begin : g_tbl
    assign fill_tbl[g] = {sine_entry(g + 1, TableBits), sine_entry(g, TableBits)};
  end

  logic [TableBits:0]   fill_cnt_q;
  logic [TableBits:0]   fill_cnt_d;
  logic                 fill_done;
  logic                 en;
  logic                 accept;
  logic [PhaseW-1:0]    sin_phase;
  logic [PhaseW-1:0]    cos_phase;
  logic [TableBits-1:0] sin_idx;
  logic [TableBits-1:0] cos_idx;
  interp_ctl_t          sin_ctl;
  interp_ctl_t          cos_ctl;
  interp_ctl_t          sin_ctl_q;
  interp_ctl_t          cos_ctl_q;
  logic [PairW-1:0]     sin_pair;
  logic [PairW-1:0]     cos_pair;
  logic [SampleWidth-1:0] sin_res;
  logic [SampleWidth-1:0] cos_res;
  logic                 s1_valid_q;
  logic                 s2_valid_q;
  logic                 out_valid_q;
  logic [31:0]          out_data_q;

  // Advance the fill counter until the table is loaded
  assign fill_done  = fill_cnt_q[TableBits];
  assign fill_cnt_d = fill_done ? fill_cnt_q : fill_cnt_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_cnt_q <= '0;
    end else begin
      fill_cnt_q <= fill_cnt_d;
    end
  end

  // Pipeline moves as a whole whenever the output register can take an item
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en && fill_done;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Sine phase and cosine phase (plus a quarter turn), wrapped to one turn
  assign sin_phase = s_axis_tdata[PhaseW-1:0];
  assign cos_phase = s_axis_tdata[PhaseW-1:0] + QuarterTurn;

  qwsc_fold #(.TableBits(TableBits)) u_fold_sin (
    .phase_i (sin_phase),
    .idx_o   (sin_idx),
    .ctl_o   (sin_ctl)
  );

  qwsc_fold #(.TableBits(TableBits)) u_fold_cos (
    .phase_i (cos_phase),
    .idx_o   (cos_idx),
    .ctl_o   (cos_ctl)
  );

  qwsc_ram #(.Width(PairW), .Depth(TableSize)) u_table (
    .clk_i     (clk_i),
    .we_i      (!fill_done),
    .waddr_i   (fill_cnt_q[TableBits-1:0]),
    .wdata_i   (fill_tbl[fill_cnt_q[TableBits-1:0]]),
    .re_i      (en),
    .raddr_a_i (sin_idx),
    .raddr_b_i (cos_idx),
    .rdata_a_o (sin_pair),
    .rdata_b_o (cos_pair)
  );

  // Hold interpolation controls alongside the RAM read
  always_ff @(posedge clk_i) begin
    if (en) begin
      sin_ctl_q <= sin_ctl;
      cos_ctl_q <= cos_ctl;
    end
  end

  qwsc_interp u_interp_sin (
    .clk_i    (clk_i),
    .en_i     (en),
    .pair_i   (sin_pair),
    .ctl_i    (sin_ctl_q),
    .result_o (sin_res)
  );

  qwsc_interp u_interp_cos (
    .clk_i    (clk_i),
    .en_i     (en),
    .pair_i   (cos_pair),
    .ctl_i    (cos_ctl_q),
    .result_o (cos_res)
  );

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= accept;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {cos_res, sin_res};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- hw/rtl/qwsc_ram.sv -----
// Generic RAM: one write port, two registered read ports.
module qwsc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered reads, held while the read enable is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ----- hw/rtl/qwsc_fold.sv -----
// Phase folding into the first quadrant: table index, fraction and sign.
module qwsc_fold #(
  parameter int unsigned TableBits = qwsc_pkg::TableBitsDef
) (
  input  logic [qwsc_pkg::PhaseW-1:0] phase_i,
  output logic [TableBits-1:0]        idx_o,
  output qwsc_pkg::interp_ctl_t       ctl_o
);
  import qwsc_pkg::*;

  localparam int unsigned FracBits = QuarterBits - TableBits;

  logic [QuarterBits:0] half_q;
  logic [QuarterBits:0] fold_q;
  logic                 at_quarter;

  // Drop the half-turn bit and mirror the second quadrant
  assign half_q = phase_i[QuarterBits:0];
  assign fold_q = half_q[QuarterBits] ?
                  (QuarterBits+1)'(HalfTurn - {1'b0, half_q}) : half_q;
  assign at_quarter = fold_q[QuarterBits];

  // Clamp index and saturate fraction at exactly a quarter turn
  always_comb begin
    ctl_o.neg = phase_i[PhaseW-1];
    if (at_quarter) begin
      idx_o      = {TableBits{1'b1}};
      ctl_o.frac = MaxQ;
    end else begin
      idx_o      = fold_q[QuarterBits-1:FracBits];
      ctl_o.frac = {fold_q[FracBits-1:0], {(MagW-FracBits){1'b0}}};
    end
  end

endmodule

// ----- hw/rtl/qwsc_interp.sv -----
// Two-stage linear interpolation between neighboring table entries, with sign.
module qwsc_interp (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [2*qwsc_pkg::MagW-1:0]       pair_i,
  input  qwsc_pkg::interp_ctl_t             ctl_i,
  output logic [qwsc_pkg::SampleWidth-1:0]  result_o
);
  import qwsc_pkg::*;

  logic [MagW-1:0]   v0;
  logic [MagW-1:0]   v1;
  logic [MagW-1:0]   diff;
  logic [2*MagW-1:0] prod_d;
  logic [2*MagW-1:0] prod_q;
  logic [MagW-1:0]   v0_q;
  logic              neg_q;
  logic [MagW-1:0]   mag;

  // Difference is never negative: entries rise over the quarter wave
  assign v0     = pair_i[MagW-1:0];
  assign v1     = pair_i[2*MagW-1:MagW];
  assign diff   = v1 - v0;
  assign prod_d = (2*MagW)'(diff) * (2*MagW)'(ctl_i.frac);

  // Register the product with the base entry and sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      v0_q   <= v0;
      neg_q  <= ctl_i.neg;
    end
  end

  // Add the scaled step and apply the half-turn sign
  assign mag      = v0_q + prod_q[2*MagW-1:MagW];
  assign result_o = neg_q ? SampleWidth'(-{1'b0, mag}) : {1'b0, mag};

endmodule

// ----- hw/rtl/qwsc_checker.sv -----
// Port-level checks for the sine/cosine lookup, bound to the top level.
module qwsc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Results never reach the most negative code
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:0] != 16'h8000) && (m_axis_tdata[31:16] != 16'h8000))
    else $error("result out of Q15 range");

  // An accepted item reaches the output when the output keeps draining
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("accepted item did not arrive");

endmodule

bind quarter_wave_sincos_lookup_top qwsc_checker u_qwsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
